// File: sv/name_table_insert_delete_search_unit_macros.svh
// Assertion macros shared by the name table RTL
`ifndef NAME_TABLE_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH
`define NAME_TABLE_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define NTIDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ntids assertion failed");

// next-cycle implication
`define NTIDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ntids assertion failed");

`endif

// File: sv/ntids_pkg.sv
// Shared widths, types and memory request struct for the name table
`timescale 1ns / 1ps
`default_nettype none

package ntids_pkg;

	localparam int ENTRIES     = 32;
	localparam int MAX_RESULTS = 32;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int N_W         = $clog2(MAX_RESULTS + 1);
	localparam int KEY_W       = 64;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int SLOT_W      = 5;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic rd;
		logic wr;
		idx_t addr;
		key_t wdata;
	} ram_req_t;

endpackage

`default_nettype wire

// File: sv/ntids_cmd_if.sv
// Command channel: mode and name key
`timescale 1ns / 1ps
`default_nettype none

interface ntids_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [ntids_pkg::MODE_W-1:0]   mode;
	logic [ntids_pkg::KEY_W-1:0]    name_key;

	modport source (output valid, mode, name_key, input ready);
	modport sink (input valid, mode, name_key, output ready);
endinterface

`default_nettype wire

// File: sv/ntids_rsp_if.sv
// Result channel: status, slot, listed key and last mark
`timescale 1ns / 1ps
`default_nettype none

interface ntids_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ntids_pkg::STATUS_W-1:0] status;
	logic [ntids_pkg::SLOT_W-1:0]   slot;
	logic [ntids_pkg::KEY_W-1:0]    listed_key;
	logic                           last;

	modport source (output valid, status, slot, listed_key, last, input ready);
	modport sink (input valid, status, slot, listed_key, last, output ready);
endinterface

`default_nettype wire

// File: sv/name_table_insert_delete_search_unit.sv
// Name table top level: slot scan sequencer, used marks and result register
// Insert, delete, search: one read per slot through the key memory port, all slots on a miss
// and fewer on an earlier hit; the result is registered from the finish state.
// List: one result per used slot as the scan passes it, up to MAX_RESULTS, or one result
// with empty status when no slot is used; the final result carries the last mark.
// One item at a time: next item accepted the cycle after the final result is registered.
// Reset clears all used marks at once; the key memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "name_table_insert_delete_search_unit_macros.svh"

module name_table_insert_delete_search_unit (
	input wire logic      clk,
	input wire logic      arst_n,
	ntids_cmd_if.sink     cmd,
	ntids_rsp_if.source   rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [ntids_pkg::MODE_W-1:0] M_INSERT = 2'd0;
	localparam logic [ntids_pkg::MODE_W-1:0] M_DELETE = 2'd1;
	localparam logic [ntids_pkg::MODE_W-1:0] M_SEARCH = 2'd2;
	localparam logic [ntids_pkg::MODE_W-1:0] M_LIST   = 2'd3;

	localparam logic [ntids_pkg::STATUS_W-1:0] S_OK        = 3'd0;
	localparam logic [ntids_pkg::STATUS_W-1:0] S_EXISTS    = 3'd1;
	localparam logic [ntids_pkg::STATUS_W-1:0] S_FULL      = 3'd2;
	localparam logic [ntids_pkg::STATUS_W-1:0] S_NOT_FOUND = 3'd3;
	localparam logic [ntids_pkg::STATUS_W-1:0] S_EMPTY     = 3'd4;

	logic [1:0]                        state_q;
	logic [ntids_pkg::MODE_W-1:0]      mode_q;
	ntids_pkg::key_t                   key_q;
	logic [ntids_pkg::CNT_W-1:0]       issue_q;
	logic                              vld_s1;
	ntids_pkg::idx_t                   idx_s1;
	logic                              found_q;
	ntids_pkg::idx_t                   hit_q;
	logic                              free_found_q;
	ntids_pkg::idx_t                   free_q;
	logic [ntids_pkg::N_W-1:0]         n_q;
	logic [ntids_pkg::ENTRIES-1:0]     used_q;

	logic                              rsp_valid_q;
	logic [ntids_pkg::STATUS_W-1:0]    rsp_status_q;
	logic [ntids_pkg::SLOT_W-1:0]      rsp_slot_q;
	ntids_pkg::key_t                   rsp_key_q;
	logic                              rsp_last_q;

	ntids_pkg::ram_req_t               ram_req;
	ntids_pkg::key_t                   rd_data;

	logic                              used_at;
	logic [ntids_pkg::ENTRIES-1:0]     above;
	logic                              more_used;
	logic                              hit;
	logic                              out_free;
	logic                              want_emit;
	logic                              stall;
	logic                              emit;
	logic                              emit_last;
	logic                              at_end;
	logic                              fin_now;
	logic                              fin_go;
	logic                              issue;
	logic                              ins_ok;
	logic [ntids_pkg::STATUS_W-1:0]    fin_status;
	ntids_pkg::idx_t                   fin_slot;

	ntids_key_ram u_key_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rd_data)
	);

	always_comb begin
		used_at   = used_q[idx_s1];
		above     = used_q >> idx_s1;
		more_used = |(above >> 1);
		hit       = (state_q == ST_SCAN) && vld_s1 && used_at && (rd_data == key_q)
			&& (mode_q != M_LIST);
		out_free  = !rsp_valid_q || rsp.ready;
		want_emit = (state_q == ST_SCAN) && vld_s1 && used_at && (mode_q == M_LIST);
		stall     = want_emit && !out_free;
		emit      = want_emit && out_free;
		emit_last = emit && (!more_used
			|| (n_q == ntids_pkg::N_W'(ntids_pkg::MAX_RESULTS - 1)));
		at_end    = idx_s1 == ntids_pkg::IDX_W'(ntids_pkg::ENTRIES - 1);
		fin_now   = (state_q == ST_SCAN) && vld_s1 && !stall && (hit || at_end || emit_last);
		fin_go    = (state_q == ST_FIN) && out_free;
		issue     = (state_q == ST_SCAN) && !stall
			&& (issue_q != ntids_pkg::CNT_W'(ntids_pkg::ENTRIES));
		ins_ok    = (mode_q == M_INSERT) && !found_q && free_found_q;

		ram_req.rd    = issue;
		ram_req.wr    = fin_go && ins_ok;
		ram_req.addr  = fin_go ? free_q : issue_q[ntids_pkg::IDX_W-1:0];
		ram_req.wdata = key_q;

		fin_status = S_NOT_FOUND;
		fin_slot   = '0;
		case (mode_q) inside
			M_INSERT: begin
				if (found_q) begin
					fin_status = S_EXISTS;
					fin_slot   = hit_q;
				end else if (free_found_q) begin
					fin_status = S_OK;
					fin_slot   = free_q;
				end else begin
					fin_status = S_FULL;
				end
			end
			M_DELETE, M_SEARCH: begin
				if (found_q) begin
					fin_status = S_OK;
					fin_slot   = hit_q;
				end
			end
			default: fin_status = S_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_s1       <= 1'b0;
			issue_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			n_q          <= '0;
			used_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						state_q      <= ST_SCAN;
						issue_q      <= '0;
						vld_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						n_q          <= '0;
					end
				end
				ST_SCAN: begin
					if (!stall && issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (fin_now) begin
						vld_s1 <= 1'b0;
					end else if (!stall) begin
						vld_s1 <= issue;
					end
					if (vld_s1 && !used_at && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (emit) begin
						n_q <= n_q + 1'b1;
					end
					if (fin_now) begin
						found_q <= hit;
						if ((mode_q == M_LIST) && (emit || (n_q != '0))) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (ins_ok) begin
							used_q[free_q] <= 1'b1;
						end
						if ((mode_q == M_DELETE) && found_q) begin
							used_q[hit_q] <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit || fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd.valid) begin
			mode_q <= cmd.mode;
			key_q  <= cmd.name_key;
		end
		if (state_q == ST_SCAN) begin
			if (!stall && issue) begin
				idx_s1 <= issue_q[ntids_pkg::IDX_W-1:0];
			end
			if (vld_s1 && !used_at && !free_found_q) begin
				free_q <= idx_s1;
			end
			if (fin_now) begin
				hit_q <= idx_s1;
			end
		end
		if (emit) begin
			rsp_status_q <= S_OK;
			rsp_slot_q   <= ntids_pkg::SLOT_W'(idx_s1);
			rsp_key_q    <= rd_data;
			rsp_last_q   <= emit_last;
		end else if (fin_go) begin
			rsp_status_q <= fin_status;
			rsp_slot_q   <= ntids_pkg::SLOT_W'(fin_slot);
			rsp_key_q    <= '0;
			rsp_last_q   <= 1'b1;
		end
	end

	assign cmd.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot       = rsp_slot_q;
	assign rsp.listed_key = rsp_key_q;
	assign rsp.last       = rsp_last_q;

	`NTIDS_ASSERT_NXT(a_ins_sets_used, clk, arst_n, fin_go && ins_ok, used_q[$past(free_q)])
	`NTIDS_ASSERT_IMP(a_hit_still_used, clk, arst_n, (state_q == ST_FIN) && found_q, used_q[hit_q])
	`NTIDS_ASSERT_IMP(a_list_cap, clk, arst_n, state_q == ST_SCAN, n_q < ntids_pkg::N_W'(ntids_pkg::MAX_RESULTS))
	`NTIDS_ASSERT_NXT(a_fin_result, clk, arst_n, fin_go, (state_q == ST_IDLE) && rsp_valid_q && rsp_last_q)

endmodule

`default_nettype wire

// File: sv/ntids_key_ram.sv
// Single-port key memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ntids_key_ram (
	input  wire logic                clk,
	input  wire ntids_pkg::ram_req_t req,
	output ntids_pkg::key_t          rdata
);

	ntids_pkg::key_t mem [ntids_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire
